@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while aresetn is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define ASSERT_CLK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hdl/s1md_pkg.sv @@
// shared types and constants for the sha-1 digest block
`default_nettype none

package s1md_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned HASH_WORDS   = 5;
    localparam int unsigned SCHED_WORDS  = 16;
    localparam int unsigned ROUND_COUNT  = 80;
    localparam int unsigned PHASE_LEN    = 20;
    localparam logic [5:0]  LAST_POS     = 6'd63;
    localparam logic [5:0]  LEN_POS      = 6'd56;
    localparam logic [2:0]  LAST_WORD_IDX = 3'd4;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;

    localparam word_t H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_CONST [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    typedef enum logic [1:0] {
        BYTE_MSG,
        BYTE_PAD,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    typedef enum logic [1:0] {
        PHASE_CH,
        PHASE_PAR1,
        PHASE_MAJ,
        PHASE_PAR2
    } phase_t;

    typedef struct packed {
        logic      init;
        logic      place;
        logic      count;
        byte_sel_t byte_sel;
        logic      round;
        phase_t    phase;
        logic      final_add;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/s1md_datapath.sv @@
// sha-1 datapath: chaining words, round registers, schedule line, byte packing, bit count
`default_nettype none

module s1md_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [7:0]           msg_byte,
    input  wire s1md_pkg::dp_cmd_t    cmd,
    input  wire logic [2:0]           word_sel,
    output s1md_pkg::dp_status_t      status,
    output logic [31:0]               digest_word
);
    import s1md_pkg::*;

    word_t       h_reg [HASH_WORDS];
    word_t       h_next [HASH_WORDS];
    word_t       w_reg [SCHED_WORDS];
    word_t       w_next [SCHED_WORDS];
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t       a_next, b_next, c_next, d_next, e_next;
    logic [23:0] acc_reg, acc_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bit_count_reg, bit_count_next;

    logic [7:0]  pb;
    word_t       sched_mix, w_new, f_val, k_val, t_sum;

    always_comb begin
        case (cmd.byte_sel)
            BYTE_MSG:  pb = msg_byte;
            BYTE_PAD:  pb = PAD_BYTE;
            BYTE_ZERO: pb = 8'h00;
            BYTE_LEN:  pb = 8'(bit_count_reg >> {~pos_reg[2:0], 3'b000});
            default:   pb = 8'h00;
        endcase
    end

    assign sched_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new     = {sched_mix[30:0], sched_mix[31]};

    always_comb begin
        case (cmd.phase)
            PHASE_CH:   f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            PHASE_PAR1: f_val = b_reg ^ c_reg ^ d_reg;
            PHASE_MAJ:  f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            PHASE_PAR2: f_val = b_reg ^ c_reg ^ d_reg;
            default:    f_val = b_reg ^ c_reg ^ d_reg;
        endcase
        k_val = K_CONST[cmd.phase];
        t_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
    end

    always_comb begin
        h_next         = h_reg;
        w_next         = w_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        bit_count_next = bit_count_reg;

        if (cmd.place) begin
            pos_next = pos_reg + 6'd1;
            acc_next = {acc_reg[15:0], pb};
            if (cmd.count) begin
                bit_count_next = bit_count_reg + 64'd8;
            end
            if (pos_reg[1:0] == 2'd3) begin
                for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[SCHED_WORDS - 1] = {acc_reg, pb};
            end
            if (pos_reg == LAST_POS) begin
                a_next = h_reg[0];
                b_next = h_reg[1];
                c_next = h_reg[2];
                d_next = h_reg[3];
                e_next = h_reg[4];
            end
        end

        if (cmd.round) begin
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[SCHED_WORDS - 1] = w_new;
            a_next = t_sum;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end

        if (cmd.final_add) begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            h_next[4] = h_reg[4] + e_reg;
        end

        if (cmd.init) begin
            h_next         = H_INIT;
            pos_next       = '0;
            bit_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg         <= H_INIT;
            pos_reg       <= '0;
            bit_count_reg <= '0;
        end else begin
            h_reg         <= h_next;
            pos_reg       <= pos_next;
            bit_count_reg <= bit_count_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        w_reg   <= w_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        acc_reg <= acc_next;
    end

    always_comb begin
        case (word_sel)
            3'd0:    digest_word = h_reg[0];
            3'd1:    digest_word = h_reg[1];
            3'd2:    digest_word = h_reg[2];
            3'd3:    digest_word = h_reg[3];
            3'd4:    digest_word = h_reg[4];
            default: digest_word = '0;
        endcase
    end

    assign status.pos = pos_reg;

endmodule

`default_nettype wire

@@ hdl/s1md_ctrl.sv @@
// sha-1 controller: byte intake, padding sequence, round count, digest output
`default_nettype none

module s1md_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_has_byte,
    input  wire logic                  s_is_last,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_word_index,
    output logic                       m_last_word,
    output s1md_pkg::dp_cmd_t          cmd,
    input  wire s1md_pkg::dp_status_t  status
);
    import s1md_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic       at_last_pos;

    assign at_last_pos = (status.pos == LAST_POS);

    always_comb begin
        cmd          = '0;
        cmd.byte_sel = BYTE_MSG;
        cmd.phase    = PHASE_CH;
        state_next   = state_reg;
        ret_next     = ret_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;

        if (rnd_reg < 7'(PHASE_LEN)) begin
            cmd.phase = PHASE_CH;
        end else if (rnd_reg < 7'(2 * PHASE_LEN)) begin
            cmd.phase = PHASE_PAR1;
        end else if (rnd_reg < 7'(3 * PHASE_LEN)) begin
            cmd.phase = PHASE_MAJ;
        end else begin
            cmd.phase = PHASE_PAR2;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_has_byte) begin
                        cmd.place    = 1'b1;
                        cmd.count    = 1'b1;
                        cmd.byte_sel = BYTE_MSG;
                    end
                    if (s_has_byte && at_last_pos) begin
                        state_next = ST_ROUND;
                        ret_next   = s_is_last ? ST_PAD80 : ST_IDLE;
                        rnd_next   = '0;
                    end else if (s_is_last) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                cmd.place    = 1'b1;
                cmd.byte_sel = BYTE_PAD;
                if (at_last_pos) begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PADZ;
                    rnd_next   = '0;
                end else begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (status.pos == LEN_POS) begin
                    state_next = ST_PADLEN;
                end else begin
                    cmd.place    = 1'b1;
                    cmd.byte_sel = BYTE_ZERO;
                    if (at_last_pos) begin
                        state_next = ST_ROUND;
                        ret_next   = ST_PADZ;
                        rnd_next   = '0;
                    end
                end
            end
            ST_PADLEN: begin
                cmd.place    = 1'b1;
                cmd.byte_sel = BYTE_LEN;
                if (at_last_pos) begin
                    state_next = ST_ROUND;
                    ret_next   = ST_OUT;
                    rnd_next   = '0;
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == 7'(ROUND_COUNT - 1)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.final_add = 1'b1;
                state_next    = ret_reg;
                if (ret_reg == ST_OUT) begin
                    m_valid_next = 1'b1;
                    idx_next     = '0;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (idx_reg == LAST_WORD_IDX) begin
                        cmd.init     = 1'b1;
                        m_valid_next = 1'b0;
                        idx_next     = '0;
                        state_next   = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            rnd_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == LAST_WORD_IDX);

endmodule

`default_nettype wire

@@ hdl/sha1_message_digest.sv @@
// sha-1 message digest, top level
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_msg_byte s_has_byte   | in
//          | s_is_last                               |
//  result  | m_valid m_ready m_digest_word           | out
//          | m_word_index m_last_word                |
//
// a byte that does not fill a block is packed into the schedule line; the 64th byte
// of a block starts the compression (one round per cycle through the round adder,
// then the chaining add). an end mark places the pad byte, any zero bytes and the
// length bytes, with up to two compressions, then the five digest words,
// one per cycle while m_ready is high.
// s_ready is low during compression, padding and digest output.
// aresetn (synchronous, active low) returns the chaining words and bit count to
// their initial values.
`default_nettype none

module sha1_message_digest (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_msg_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_is_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);
    import s1md_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    s1md_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_has_byte   (s_has_byte),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_last_word  (m_last_word),
        .cmd          (cmd),
        .status       (status)
    );

    s1md_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .msg_byte    (s_msg_byte),
        .cmd         (cmd),
        .word_sel    (m_word_index),
        .status      (status),
        .digest_word (m_digest_word)
    );

endmodule

`default_nettype wire

@@ hdl/s1md_checker.sv @@
// port-level checks for the sha-1 digest block, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module s1md_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_digest_word,
    input wire logic [2:0]  m_word_index,
    input wire logic        m_last_word
);
    import s1md_pkg::*;

    logic        out_stall;
    logic        out_step;
    logic        idx_ok;
    logic [2:0]  idx_inc;
    logic [35:0] out_payload;

    assign out_stall   = m_valid && !m_ready;
    assign out_step    = m_valid && m_ready && !m_last_word;
    assign idx_inc     = m_word_index + 3'd1;
    assign out_payload = {m_digest_word, m_word_index, m_last_word};
    assign idx_ok      = (m_last_word == (m_word_index == LAST_WORD_IDX)) &&
                         (m_word_index <= LAST_WORD_IDX);

    // a stalled result transaction holds its payload
    `ASSERT_CLK(a_out_hold, out_stall |=> m_valid && $stable(out_payload), "stalled result changed")

    // last flag marks exactly the fifth word
    `ASSERT_CLK(a_last_flag, m_valid |-> idx_ok, "bad word index or last flag")

    // digest words follow each other in order
    `ASSERT_CLK(a_word_order, out_step |=> m_valid && (m_word_index == $past(idx_inc)), "word skipped")

    // no input transaction while a digest is being delivered
    `ASSERT_CLK(a_no_overlap, m_valid |-> !s_ready, "input taken during digest output")

    // reset leaves no result pending
    `ASSERT_CLK_RST(a_reset_clear, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind sha1_message_digest s1md_checker u_checker (.*);

`default_nettype wire

@@ bench/tb_sha1_message_digest.sv @@
// sha-1 digest block testbench: directed and random byte-stream messages checked against a built-in hash model
`timescale 1ns / 1ps

class sha1_scoreboard;
    typedef struct {
        bit [31:0] word;
        bit [2:0]  index;
        bit        last;
    } digest_item_t;

    bit [31:0]    chain [5];
    bit [31:0]    block_words [16];
    bit [63:0]    length_bits;
    digest_item_t digest_queue [$];
    int unsigned  errors;
    int unsigned  words_checked;
    int unsigned  messages;
    int unsigned  bytes_seen;

    function new();
        restart_chain();
        foreach (block_words[i]) block_words[i] = '0;
        errors = 0;
        words_checked = 0;
        messages = 0;
        bytes_seen = 0;
    endfunction

    function void restart_chain();
        foreach (chain[i]) chain[i] = s1md_pkg::H_INIT[i];
        length_bits = '0;
    endfunction

    function void compress_block();
        bit [31:0] w [16];
        bit [31:0] a, b, c, d, e, f, wt, tmp;
        w = block_words;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                wt = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
                wt = {wt[30:0], wt[31]};
                w[t % 16] = wt;
            end
            case (t / 20)
                0: f = (b & c) | (~b & d);
                2: f = (b & c) | (b & d) | (c & d);
                default: f = b ^ c ^ d;
            endcase
            tmp = {a[26:0], a[31:27]} + f + e + s1md_pkg::K_CONST[t / 20] + wt;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function void place_byte(bit [5:0] pos, bit [7:0] value);
        int sh;
        sh = 24 - 8 * pos[1:0];
        if (pos[1:0] == 2'd0) begin
            block_words[pos[5:2]] = {value, 24'h000000};
        end else begin
            block_words[pos[5:2]][sh +: 8] = value;
        end
        if (pos == s1md_pkg::LAST_POS) compress_block();
    endfunction

    function void note_input(bit [7:0] value, bit has, bit last);
        bit [5:0]     pos;
        bit [63:0]    len;
        digest_item_t item;
        if (has) begin
            pos = length_bits[8:3];
            length_bits += 64'd8;
            place_byte(pos, value);
            bytes_seen++;
        end
        if (!last) return;
        len = length_bits;
        pos = len[8:3];
        place_byte(pos, s1md_pkg::PAD_BYTE);
        pos++;
        while (pos != s1md_pkg::LEN_POS) begin
            place_byte(pos, 8'h00);
            pos++;
        end
        for (int i = 0; i < 8; i++) place_byte(6'(s1md_pkg::LEN_POS + i), len[8 * (7 - i) +: 8]);
        for (int i = 0; i < 5; i++) begin
            item.word  = chain[i];
            item.index = 3'(i);
            item.last  = (3'(i) == s1md_pkg::LAST_WORD_IDX);
            digest_queue.insert(digest_queue.size(), item);
        end
        restart_chain();
        messages++;
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("ERROR %0t: %s", $realtime, msg);
    endfunction

    function void check_result(bit [31:0] word, bit [2:0] index, bit last);
        digest_item_t want;
        if (digest_queue.size() == 0) begin
            flag($sformatf("unexpected digest transaction word %08h index %0d last %0d",
                           word, index, last));
            return;
        end
        want = digest_queue.pop_front();
        words_checked++;
        if (want.word != word || want.index != index || want.last != last) begin
            flag($sformatf("expected word %08h index %0d last %0d, got %08h %0d %0d",
                           want.word, want.index, want.last, word, index, last));
        end
    endfunction
endclass

module tb_sha1_message_digest;
    import s1md_pkg::*;

    localparam int unsigned PHASE_ITEMS = 75;
    localparam int unsigned COOLDOWN    = 300;
    localparam int unsigned DRAIN_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_msg_byte = 8'h00;
    logic        s_has_byte = 1'b0;
    logic        s_is_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    sha1_scoreboard sb = new();
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    items_sent = 0;

    sha1_message_digest u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_msg_byte    (s_msg_byte),
        .s_has_byte    (s_has_byte),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_digest_word, m_word_index, m_last_word);
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(logic [7:0] value, logic has, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_msg_byte <= value;
        s_has_byte <= has;
        s_is_last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(value, has, last);
        items_sent++;
    endtask

    task automatic send_message(int unsigned len);
        bit merge_end;
        merge_end = (len != 0) && ($urandom_range(1) == 1);
        for (int unsigned n = 0; n < len; n++) begin
            if ($urandom_range(7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, merge_end && (n == len - 1));
        end
        if (!merge_end) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int unsigned pick_length();
        case ($urandom_range(5))
            0: return $urandom_range(3);
            1: return 55 + $urandom_range(10);
            2: return 119 + $urandom_range(2);
            default: return $urandom_range(40);
        endcase
    endfunction

    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        while (sb.digest_queue.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (COOLDOWN) @(posedge aclk);
    endtask

    initial begin
        int unsigned start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle item, empty message, then short messages with separate or merged end marks
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) send_message(pick_length());
            drain_results();
        end

        if (sb.digest_queue.size() != 0) begin
            sb.flag($sformatf("%0d digest words never arrived", sb.digest_queue.size()));
        end
        $display("run covered %0d messages, %0d message bytes, %0d digest words checked",
                 sb.messages, sb.bytes_seen, sb.words_checked);
        $display("idle and stall phases at 0, 73 and 31 percent, %0d errors", sb.errors);
        if (sb.errors == 0) begin
            $display("sha1_message_digest: match");
        end else begin
            $display("sha1_message_digest: mismatch");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("timeout waiting for transactions");
        $display("sha1_message_digest: mismatch");
        $finish;
    end
endmodule
